// ===== hw/rtl/tiled_palette_framebuffer_engine_core_defines.svh =====
// assertion helpers
`ifndef TILED_PALETTE_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH
`define TILED_PALETTE_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH

`define TPFE_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tpfe assertion failed");

`define TPFE_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tpfe assertion failed");

`endif

// ===== hw/rtl/tpfe_pkg.sv =====
`default_nettype none
package tpfe_pkg;

    localparam logic [3:0] FUNC_CLEAR   = 4'd0;
    localparam logic [3:0] FUNC_BG      = 4'd1;
    localparam logic [3:0] FUNC_FG      = 4'd2;
    localparam logic [3:0] FUNC_PALSEL  = 4'd3;
    localparam logic [3:0] FUNC_X       = 4'd4;
    localparam logic [3:0] FUNC_Y       = 4'd5;
    localparam logic [3:0] FUNC_W       = 4'd6;
    localparam logic [3:0] FUNC_H       = 4'd7;
    localparam logic [3:0] FUNC_PLOT    = 4'd8;
    localparam logic [3:0] FUNC_BLIT    = 4'd9;
    localparam logic [3:0] FUNC_SYNC    = 4'd10;
    localparam logic [3:0] FUNC_PALWR   = 4'd11;

    localparam int MAX_OUT = 64;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_PLOT      = 7'b0000010,
        ST_CLR_RD    = 7'b0000100,
        ST_CLR_TILE  = 7'b0001000,
        ST_CLR_FILL  = 7'b0010000,
        ST_SYNC_SCAN = 7'b0100000,
        ST_SYNC_LAST = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tiled_palette_framebuffer_engine_core.sv =====
`default_nettype none
// tiled palette framebuffer draw engine
// a request is taken at a rising edge with start high and busy low; the
// request fields are func, value, blit_dx, blit_dy, pal_number, pal_entry
// register commands (colours, palette select, x/y/w/h, palette write) are
// done at the accepting edge; plot and blit pixel first read the palette
// memory, then write the pixel memory and tile flags in ST_PLOT
// clear reads the background colour from the palette, then fills every tile
// not already clear in that colour, one pixel memory write per cycle
// sync walks one tile flag per cycle and stops after the last tile or once 64
// tiles have been found; each dirty tile is shown on tile_row, tile_column
// and last for one cycle with strobe high, one dirty tile behind the walk
// the receiver cannot stall, so results are never held back
// reset sets the window and colours to their defaults, marks every tile
// dirty and not clear; palette and pixel memories are not cleared
module tiled_palette_framebuffer_engine_core
    import tpfe_pkg::*;
#(
    parameter int SCREEN_W = 256,
    parameter int SCREEN_H = 192,
    parameter int TILE_W   = 32,
    parameter int TILE_H   = 24,
    parameter int PALETTES = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  func,
    input  wire logic [15:0] value,
    input  wire logic [15:0] blit_dx,
    input  wire logic [15:0] blit_dy,
    input  wire logic [3:0]  pal_number,
    input  wire logic [7:0]  pal_entry,
    output logic             strobe,
    output logic [2:0]       tile_row,
    output logic [2:0]       tile_column,
    output logic             last
);

    localparam int TCOLS    = SCREEN_W / TILE_W;
    localparam int TROWS    = SCREEN_H / TILE_H;
    localparam int NTILES   = TCOLS * TROWS;
    localparam int AREA_W   = TCOLS * TILE_W;
    localparam int AREA_H   = TROWS * TILE_H;
    localparam int TILE_PIX = TILE_W * TILE_H;
    localparam int PIX_D    = NTILES * TILE_PIX;
    localparam int PAL_D    = PALETTES * 256;
    localparam int PIX_AW   = $clog2(PIX_D);
    localparam int PAL_AW   = $clog2(PAL_D);
    localparam int TIDX_W   = (NTILES > 1) ? $clog2(NTILES) : 1;
    localparam int CW       = (TCOLS > 1) ? $clog2(TCOLS) : 1;
    localparam int RW       = (TROWS > 1) ? $clog2(TROWS) : 1;
    localparam int PW       = $clog2(TILE_PIX);
    localparam int CNT_W    = $clog2(MAX_OUT);

    logic [15:0] palette_mem [PAL_D];
    logic [15:0] pixel_mem   [PIX_D];

    state_t state_reg, state_next;

    logic [15:0] pos_x_reg, pos_y_reg, win_w_reg, win_h_reg;
    logic [7:0]  back_colour_reg, fore_colour_reg, last_fill_reg;
    logic [3:0]  active_pal_reg;
    logic [NTILES-1:0] tile_dirty_reg, tile_clear_reg;

    logic [15:0]       pal_rdata_reg;
    logic [PAL_AW-1:0] pal_raddr;

    logic [PIX_AW-1:0] plot_addr_reg;
    logic [TIDX_W-1:0] plot_tile_reg;

    logic [15:0]       clr_colour_reg;
    logic [PIX_AW-1:0] clr_addr_reg;
    logic [PW-1:0]     clr_pix_reg;

    logic [TIDX_W-1:0] scan_t_reg;
    logic [RW-1:0]     scan_row_reg, pend_row_reg;
    logic [CW-1:0]     scan_col_reg, pend_col_reg;
    logic              pend_valid_reg;
    logic [CNT_W-1:0]  found_reg;

    logic              strobe_reg, last_reg;
    logic [2:0]        row_out_reg, col_out_reg;

    logic        accept;
    logic [16:0] draw_x, draw_y;
    logic        draw_ok;
    logic [TCOLS-1:0] col_ge;
    logic [TROWS-1:0] row_ge;
    logic [CW-1:0]     draw_col;
    logic [RW-1:0]     draw_row;
    logic [TIDX_W-1:0] draw_tile;
    logic [PIX_AW-1:0] draw_addr;
    logic [16:0]       local_x, local_y;
    logic              scan_hit, scan_end;
    logic              clr_skip;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        if (func == FUNC_BLIT)
        begin
            draw_x  = {1'b0, pos_x_reg} + {1'b0, blit_dx};
            draw_y  = {1'b0, pos_y_reg} + {1'b0, blit_dy};
            draw_ok = (blit_dx < win_w_reg) && (blit_dy < win_h_reg) && (value[7:0] != 8'd0);
        end
        else
        begin
            draw_x  = {1'b0, pos_x_reg};
            draw_y  = {1'b0, pos_y_reg};
            draw_ok = 1'b1;
        end
        draw_ok = draw_ok && (draw_x < 17'(AREA_W)) && (draw_y < 17'(AREA_H));
        col_ge = '0;
        for (int k = 1; k < TCOLS; k++)
        begin
            col_ge[k] = (draw_x >= 17'(k * TILE_W));
        end
        row_ge = '0;
        for (int k = 1; k < TROWS; k++)
        begin
            row_ge[k] = (draw_y >= 17'(k * TILE_H));
        end
        draw_col  = CW'($countones(col_ge));
        draw_row  = RW'($countones(row_ge));
        local_x   = draw_x - 17'(draw_col) * 17'(TILE_W);
        local_y   = draw_y - 17'(draw_row) * 17'(TILE_H);
        draw_tile = TIDX_W'(TIDX_W'(draw_row) * TIDX_W'(TCOLS) + TIDX_W'(draw_col));
        draw_addr = PIX_AW'(draw_tile) * PIX_AW'(TILE_PIX)
                  + PIX_AW'(local_y) * PIX_AW'(TILE_W) + PIX_AW'(local_x);
    end

    always_comb
    begin
        if (func == FUNC_CLEAR)
            pal_raddr = PAL_AW'(PAL_AW'(active_pal_reg) * PAL_AW'(256)
                                + PAL_AW'(back_colour_reg));
        else
            pal_raddr = PAL_AW'(PAL_AW'(active_pal_reg) * PAL_AW'(256)
                                + PAL_AW'(value[7:0]));
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_PALWR && 32'(pal_number) < PALETTES)
            palette_mem[PAL_AW'(PAL_AW'(pal_number) * PAL_AW'(256) + PAL_AW'(pal_entry))]
                <= value;
        pal_rdata_reg <= palette_mem[pal_raddr];
    end

    // pixel memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PLOT)
            pixel_mem[plot_addr_reg] <= pal_rdata_reg;
        else if (state_reg == ST_CLR_FILL)
            pixel_mem[clr_addr_reg] <= clr_colour_reg;
    end

    assign scan_hit = tile_dirty_reg[scan_t_reg];
    assign scan_end = (scan_t_reg == TIDX_W'(NTILES - 1))
                   || (scan_hit && found_reg == CNT_W'(MAX_OUT - 1));
    assign clr_skip = tile_clear_reg[scan_t_reg] && (last_fill_reg == back_colour_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((func == FUNC_PLOT || func == FUNC_BLIT) && draw_ok)
                        state_next = ST_PLOT;
                    else if (func == FUNC_CLEAR)
                        state_next = ST_CLR_RD;
                    else if (func == FUNC_SYNC)
                        state_next = ST_SYNC_SCAN;
                end
            end
            ST_PLOT:      state_next = ST_IDLE;
            ST_CLR_RD:    state_next = ST_CLR_TILE;
            ST_CLR_TILE:
            begin
                if (!clr_skip)
                    state_next = ST_CLR_FILL;
                else if (scan_t_reg == TIDX_W'(NTILES - 1))
                    state_next = ST_IDLE;
            end
            ST_CLR_FILL:
            begin
                if (clr_pix_reg == PW'(TILE_PIX - 1))
                    state_next = (scan_t_reg == TIDX_W'(NTILES - 1)) ? ST_IDLE : ST_CLR_TILE;
            end
            ST_SYNC_SCAN:
            begin
                if (scan_end)
                    state_next = ST_SYNC_LAST;
            end
            ST_SYNC_LAST: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            win_w_reg       <= '0;
            win_h_reg       <= '0;
            back_colour_reg <= '0;
            fore_colour_reg <= 8'hff;
            active_pal_reg  <= '0;
            last_fill_reg   <= '0;
            tile_dirty_reg  <= '1;
            tile_clear_reg  <= '0;
            scan_t_reg      <= '0;
            scan_row_reg    <= '0;
            scan_col_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            found_reg       <= '0;
            clr_pix_reg     <= '0;
            clr_addr_reg    <= '0;
            strobe_reg      <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_t_reg     <= '0;
                    scan_row_reg   <= '0;
                    scan_col_reg   <= '0;
                    pend_valid_reg <= 1'b0;
                    found_reg      <= '0;
                    clr_addr_reg   <= '0;
                    clr_pix_reg    <= '0;
                    if (accept)
                    begin
                        case (func)
                            FUNC_BG:     back_colour_reg <= value[7:0];
                            FUNC_FG:     fore_colour_reg <= value[7:0];
                            FUNC_PALSEL:
                            begin
                                if (32'(value) < PALETTES)
                                    active_pal_reg <= value[3:0];
                            end
                            FUNC_X:      pos_x_reg <= value;
                            FUNC_Y:      pos_y_reg <= value;
                            FUNC_W:      win_w_reg <= value;
                            FUNC_H:      win_h_reg <= value;
                            default:     ;
                        endcase
                    end
                end
                ST_PLOT:
                begin
                    tile_dirty_reg[plot_tile_reg] <= 1'b1;
                    tile_clear_reg[plot_tile_reg] <= 1'b0;
                end
                ST_CLR_RD: ;
                ST_CLR_TILE:
                begin
                    clr_pix_reg <= '0;
                    if (clr_skip)
                    begin
                        clr_addr_reg <= clr_addr_reg + PIX_AW'(TILE_PIX);
                        scan_t_reg   <= scan_t_reg + TIDX_W'(1);
                        if (scan_t_reg == TIDX_W'(NTILES - 1))
                            last_fill_reg <= back_colour_reg;
                    end
                end
                ST_CLR_FILL:
                begin
                    clr_addr_reg <= clr_addr_reg + PIX_AW'(1);
                    clr_pix_reg  <= clr_pix_reg + PW'(1);
                    if (clr_pix_reg == PW'(TILE_PIX - 1))
                    begin
                        tile_clear_reg[scan_t_reg] <= 1'b1;
                        tile_dirty_reg[scan_t_reg] <= 1'b1;
                        scan_t_reg <= scan_t_reg + TIDX_W'(1);
                        if (scan_t_reg == TIDX_W'(NTILES - 1))
                            last_fill_reg <= back_colour_reg;
                    end
                end
                ST_SYNC_SCAN:
                begin
                    if (scan_hit)
                    begin
                        if (pend_valid_reg)
                            strobe_reg <= 1'b1;
                        pend_valid_reg             <= 1'b1;
                        found_reg                  <= found_reg + CNT_W'(1);
                        tile_dirty_reg[scan_t_reg] <= 1'b0;
                    end
                    scan_t_reg <= scan_t_reg + TIDX_W'(1);
                    if (scan_col_reg == CW'(TCOLS - 1))
                    begin
                        scan_col_reg <= '0;
                        scan_row_reg <= scan_row_reg + RW'(1);
                    end
                    else
                        scan_col_reg <= scan_col_reg + CW'(1);
                end
                ST_SYNC_LAST:
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // pending tile and request payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plot_addr_reg <= draw_addr;
            plot_tile_reg <= draw_tile;
        end
        if (state_reg == ST_CLR_RD)
            clr_colour_reg <= pal_rdata_reg;
        if (state_reg == ST_SYNC_SCAN && scan_hit)
        begin
            pend_row_reg <= scan_row_reg;
            pend_col_reg <= scan_col_reg;
            row_out_reg  <= 3'(pend_row_reg);
            col_out_reg  <= 3'(pend_col_reg);
        end
        if (state_reg == ST_SYNC_LAST)
        begin
            row_out_reg <= 3'(pend_row_reg);
            col_out_reg <= 3'(pend_col_reg);
        end
    end

    assign strobe      = strobe_reg;
    assign last        = last_reg;
    assign tile_row    = row_out_reg;
    assign tile_column = col_out_reg;

`include "tiled_palette_framebuffer_engine_core_defines.svh"

    `TPFE_ASSERT_NEXT(a_strobe_from_sync, !(state_reg == ST_SYNC_SCAN || state_reg == ST_SYNC_LAST), !strobe_reg)
    `TPFE_ASSERT_NEXT(a_last_ends_burst, strobe_reg && last_reg, !strobe_reg)
    `TPFE_ASSERT_NEXT(a_plot_marks_dirty, state_reg == ST_PLOT, tile_dirty_reg[$past(plot_tile_reg)])

endmodule
`default_nettype wire
